### hdl/lpf_pkg.sv
// Shared constants and the coefficient function for the 37-tap lowpass FIR.
// No dependencies; used by lowpass_fir_37_tap and by the bench tb_top.
package lpf_pkg;

	localparam int TAP_COUNT_DEF      = 37;
	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int COEF_FRAC_BITS_DEF = 17;

	// Source table: signed Q1.17, symmetric about the center tap.
	localparam int TABLE_TAPS = 37;
	localparam int TABLE_FRAC = 17;
	localparam int COEF_Q17 [TABLE_TAPS] = '{
		-49, -93, -156, -218, -248, -204, -31, 330, 930, 1809,
		2976, 4407, 6038, 7768, 9467, 10992, 12202, 12980, 13249,
		12980, 12202, 10992, 9467, 7768, 6038, 4407, 2976, 1809,
		930, 330, -31, -204, -248, -218, -156, -93, -49
	};

	// Headroom for the sum of up to 128 taps.
	localparam int GROWTH_BITS = 7;

	// Coefficient k requantized to frac fractional bits; round half up when
	// dropping bits, zero past the end of the table.
	function automatic logic signed [31:0] tap_coef(input int k, input int frac);
		logic signed [31:0] c;
		c = '0;
		if (k < TABLE_TAPS) begin
			c = COEF_Q17[k];
			if (frac >= TABLE_FRAC) begin
				c = c <<< (frac - TABLE_FRAC);
			end else begin
				c = (c + (32'sd1 <<< (TABLE_FRAC - frac - 1))) >>> (TABLE_FRAC - frac);
			end
		end
		return c;
	endfunction

endpackage

### hdl/lpf_cell.sv
// One tap of the transposed FIR: multiply the new sample by a fixed
// coefficient and add the neighbor's partial sum. Uses no package items.
module lpf_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_W      = 19,
	parameter int ACC_W       = 42,
	parameter logic signed [COEF_W-1:0] COEF = '0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] x,
	input  logic signed [ACC_W-1:0]       sum_in,
	output logic signed [ACC_W-1:0]       sum_out
);

	localparam int PROD_W = SAMPLE_BITS + COEF_W;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  sum_q;

	assign prod = x * COEF;

	// Partial sum is filter state: zero after reset matches an all-zero history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (en) begin
			sum_q <= sum_in + ACC_W'(prod);
		end
	end

	assign sum_out = sum_q;

endmodule

### hdl/lpf_out.sv
// Output stage: rounds the full-width sum to nearest (ties up), saturates to
// the sample width and holds the result for the downstream transfer.
module lpf_out #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 17,
	parameter int ACC_W          = 42
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [ACC_W-1:0]       acc,
	input  logic                          acc_valid,
	output logic                          acc_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered_out,
	output logic                          out_valid,
	input  logic                          out_ready
);

	localparam int RND_W = ACC_W + 1;
	localparam int Y_W   = RND_W - COEF_FRAC_BITS;
	localparam int TOP_W = Y_W - SAMPLE_BITS + 1;

	logic signed [RND_W-1:0]       rnd;
	logic signed [Y_W-1:0]         y;
	logic [TOP_W-1:0]              top;
	logic signed [SAMPLE_BITS-1:0] sat;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] data_q;

	assign rnd = RND_W'(acc) + (RND_W'(1) <<< (COEF_FRAC_BITS - 1));
	assign y   = Y_W'(rnd >>> COEF_FRAC_BITS);
	assign top = y[Y_W-1:SAMPLE_BITS-1];

	always_comb begin
		if (top == '0 || top == '1) begin
			sat = y[SAMPLE_BITS-1:0];
		end else if (y[Y_W-1]) begin
			sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	assign acc_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_ready) begin
			out_valid_q <= acc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_ready && acc_valid) begin
			data_q <= sat;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_out = data_q;

endmodule

### hdl/lowpass_fir_37_tap.sv
// Top level of the 37-tap symmetric lowpass FIR: a row of lpf_cell taps in
// transposed form feeding lpf_out. Depends on lpf_pkg, lpf_cell, lpf_out.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid, in_ready, sample_in            | in
//   output   | out_valid, out_ready, filtered_out       | out
//
// One sample per clock sustained while out_ready stays high; each result passes
// the sum register in tap 0, then the rounding/output register.
// The tap chain advances only on an input transfer, so stalls on either side
// never disturb the filter history. Reset clears every partial sum, which
// is the same as an all-zero sample history. in_ready follows out_ready
// through the two-deep output path.
module lowpass_fir_37_tap #(
	parameter int TAP_COUNT      = lpf_pkg::TAP_COUNT_DEF,
	parameter int SAMPLE_BITS    = lpf_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = lpf_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic signed [SAMPLE_BITS-1:0] filtered_out,
	output logic                          out_valid,
	input  logic                          out_ready
);

	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int ACC_W  = SAMPLE_BITS + COEF_W + lpf_pkg::GROWTH_BITS;

	logic signed [ACC_W-1:0] chain [TAP_COUNT+1];
	logic                    accept;
	logic                    valid_s1;
	logic                    s1_ready;
	logic                    s1_adv;

	assign s1_adv   = !valid_s1 || s1_ready;
	assign in_ready = s1_adv;
	assign accept   = in_valid && in_ready;

	assign chain[TAP_COUNT] = '0;

	// Cell k holds sum of h[j]*x[n+k-j] for j >= k; cell 0 holds the full sum.
	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
		lpf_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.COEF_W     (COEF_W),
			.ACC_W      (ACC_W),
			.COEF       (COEF_W'(lpf_pkg::tap_coef(k, COEF_FRAC_BITS)))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.x      (sample_in),
			.sum_in (chain[k+1]),
			.sum_out(chain[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= in_valid;
		end
	end

	lpf_out #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.ACC_W         (ACC_W)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (chain[0]),
		.acc_valid   (valid_s1),
		.acc_ready   (s1_ready),
		.filtered_out(filtered_out),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

### bench/tb_top.sv
// Self-checking bench for the 37-tap lowpass FIR: a scoreboard that filters
// every accepted sample on its own, plus drivers for both handshakes.
// Depends on the lowpass_fir_37_tap RTL and on lpf_pkg for the port defaults.
package fir_check_pkg;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTAPS = 37;
	localparam int FRAC  = 17;

	// Lowpass impulse response, signed Q1.17, symmetric about tap 18.
	localparam int TAP_WEIGHT [NTAPS] = '{
		-49, -93, -156, -218, -248, -204, -31, 330, 930, 1809,
		2976, 4407, 6038, 7768, 9467, 10992, 12202, 12980, 13249,
		12980, 12202, 10992, 9467, 7768, 6038, 4407, 2976, 1809,
		930, 330, -31, -204, -248, -218, -156, -93, -49
	};

	class fir_scoreboard;
		logic signed [15:0] history [NTAPS-1];
		logic signed [15:0] filtered_q [$];
		int unsigned samples_seen;
		int unsigned results_seen;
		int unsigned clipped;
		int unsigned errors;

		function new();
			foreach (history[i]) history[i] = '0;
			samples_seen = 0;
			results_seen = 0;
			clipped = 0;
			errors = 0;
		endfunction

		function int pending();
			return filtered_q.size();
		endfunction

		// Accepted sample: run the convolution, shift the history, queue y[n].
		function void note_sample(logic signed [15:0] x);
			longint acc;
			logic signed [15:0] y;
			acc = longint'(TAP_WEIGHT[0]) * longint'(x);
			for (int k = 1; k < NTAPS; k++) begin
				acc += longint'(TAP_WEIGHT[k]) * longint'(history[k-1]);
			end
			for (int k = NTAPS - 2; k > 0; k--) begin
				history[k] = history[k-1];
			end
			history[0] = x;
			// round half up, then floor shift
			acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
			if (acc > 32767) begin
				y = 16'sh7fff;
				clipped++;
			end else if (acc < -32768) begin
				y = 16'sh8000;
				clipped++;
			end else begin
				y = acc[15:0];
			end
			filtered_q.push_back(y);
			samples_seen++;
		endfunction

		function void check_result(logic signed [15:0] y);
			logic signed [15:0] want;
			results_seen++;
			if (filtered_q.size() == 0) begin
				errors++;
				$display("t=%0d ns: filtered_out expected none, got %0d", $time, y);
				return;
			end
			want = filtered_q.pop_front();
			if (y !== want) begin
				errors++;
				$display("t=%0d ns: filtered_out expected %0d, got %0d", $time, want, y);
			end
		endfunction
	endclass

endpackage

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW          = lpf_pkg::SAMPLE_BITS_DEF;
	localparam int ITEMS_PHASE = 270;

	logic clk = 1'b0;
	logic arst_n;
	logic signed [SW-1:0] sample_in;
	logic in_valid;
	logic in_ready;
	logic signed [SW-1:0] filtered_out;
	logic out_valid;
	logic out_ready;

	int tx_idle_pct;
	int rx_stall_pct;
	int unsigned sent;

	fir_check_pkg::fir_scoreboard sb = new();

	lowpass_fir_37_tap dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_in    (sample_in),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.filtered_out (filtered_out),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

	always #5 clk = ~clk;

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.note_sample(sample_in);
		end
	end

	// output transfers are checked; ready toggles at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(filtered_out);
		end
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	task automatic send_sample(input logic signed [SW-1:0] s);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// hold off the sender until the filter has drained
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [SW-1:0] extreme();
		return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
	endfunction

	// one random stretch of stimulus
	task automatic send_burst();
		int kind;
		int len;
		logic signed [SW-1:0] v;
		kind = $urandom_range(4);
		case (kind)
			0: begin
				len = $urandom_range(20, 1);
				repeat (len) send_sample(SW'($urandom()));
			end
			1: begin
				// long constant run; with DC gain above one, a large value drives the output into clipping
				v = $urandom_range(2) == 0 ? SW'($urandom()) : extreme();
				len = $urandom_range(45, 37);
				repeat (len) send_sample(v);
			end
			2: begin
				send_sample($urandom_range(1) ? extreme() : SW'($urandom()));
				len = $urandom_range(40, 1);
				repeat (len) send_sample('0);
			end
			3: begin
				v = extreme();
				len = $urandom_range(40, 10);
				repeat (len) begin
					send_sample(v);
					v = ~v;
				end
			end
			default: begin
				len = $urandom_range(20, 1);
				repeat (len) send_sample($signed(16'($urandom_range(8))) - 16'sd4);
			end
		endcase
	endtask

	initial begin
		logic signed [SW-1:0] directed [24] = '{
			16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000,
			16'sh8000, 16'sh0000, 16'sh0000,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh0001, 16'shffff, 16'sh0000, 16'sh5555, 16'shaaaa,
			16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000
		};
		int unsigned waited;

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		sent         = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_sample(directed[i]);
		drain_outputs();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
				default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
			endcase
			waited = sent;
			while (sent - waited < ITEMS_PHASE) send_burst();
			drain_outputs();
		end

		rx_stall_pct = 0;
		waited = 0;
		while (sb.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors += sb.pending();
			$display("t=%0d ns: %0d filtered samples never arrived", $time, sb.pending());
		end

		$display("Filtered %0d samples, checked %0d outputs, %0d of them clipped;",
			sb.samples_seen, sb.results_seen, sb.clipped);
		$display("ran free-flowing, sender-idle, receiver-stall and mixed phases.");
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

### lowpass_fir_37_tap.f
hdl/lpf_pkg.sv
hdl/lpf_cell.sv
hdl/lpf_out.sv
hdl/lowpass_fir_37_tap.sv
bench/tb_top.sv
